/* design/glcm_pair_counter_unit_assert.svh */
// Assertion macros used by the checker file of the co-occurrence counter.
`ifndef GLCM_PAIR_COUNTER_UNIT_ASSERT_SVH
`define GLCM_PAIR_COUNTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpc assertion failed");

`endif

/* design/gpc_pkg.sv */
package gpc_pkg;

   // Fixed field widths of the streams and the register port.
   localparam int PIXEL_BITS      = 8;
   localparam int COUNT_OUT_BITS  = 32;
   localparam int REQ_DATA_BITS   = 24;
   localparam int WIDTH_REG_BITS  = 13;
   localparam int HEIGHT_REG_BITS = 16;
   localparam int DIR_REG_BITS    = 2;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 13'd4096;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_DIRECTION
   } csr_reg_type;

   // Neighbour direction: left, up-right, up, up-left.
   typedef enum logic [DIR_REG_BITS-1:0] {
      DIR_LEFT,
      DIR_UP_RIGHT,
      DIR_UP,
      DIR_UP_LEFT
   } direction_type;

   typedef enum logic {
      ACTION_PIXEL,
      ACTION_READ
   } action_type;

   // Where the neighbour value of a pixel comes from.
   typedef enum logic [1:0] {
      Q_LEFT,
      Q_ABOVE,
      Q_ABOVE_NEXT,
      Q_ABOVE_LEFT
   } qsel_type;

   // Operation applied to one bin by the read-modify-write pipeline.
   typedef enum logic [1:0] {
      OP_INC1,
      OP_INC2,
      OP_CLEAR
   } bin_op_type;

   typedef struct packed {
      logic [WIDTH_REG_BITS-1:0]  width;
      logic [HEIGHT_REG_BITS-1:0] height;
      direction_type              direction;
   } cfg_type;

   // One item handed from the pixel front end to the pair sequencer.
   typedef struct packed {
      action_type            action;
      logic [PIXEL_BITS-1:0] p;
      logic [PIXEL_BITS-1:0] q;
      logic [PIXEL_BITS-1:0] bin_row;
      logic [PIXEL_BITS-1:0] bin_col;
   } pair_item_type;

   typedef struct packed {
      logic       valid;
      bin_op_type op;
   } bin_slot_type;

endpackage

/* design/gpc_pixel_front.sv */
module gpc_pixel_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int LEVEL_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gpc_pkg::action_type                  req_action,
   input  logic [gpc_pkg::PIXEL_BITS-1:0]       req_pixel,
   input  logic [gpc_pkg::PIXEL_BITS-1:0]       req_bin_row,
   input  logic [gpc_pkg::PIXEL_BITS-1:0]       req_bin_col,
   input  gpc_pkg::cfg_type                     cfg,
   input  logic                                 hold,
   output logic                                 item_valid,
   output gpc_pkg::pair_item_type               item,
   input  logic                                 item_ready
);
   import gpc_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int WBITS    = (COL_BITS + 1 > WIDTH_REG_BITS) ? COL_BITS + 1 : WIDTH_REG_BITS;

   // Position in the frame and the neighbour registers.
   logic [COL_BITS-1:0]        col_ff, col_in;
   logic [HEIGHT_REG_BITS-1:0] row_ff, row_in;
   logic [LEVEL_BITS-1:0]      left_ff, left_in;
   logic [LEVEL_BITS-1:0]      above_left_ff, above_left_in;

   // Accepted item waiting for its row buffer read data.
   logic                  a_valid_ff, a_valid_in;
   action_type            a_action_ff, a_action_in;
   logic                  a_pair_ff, a_pair_in;
   qsel_type              a_qsel_ff, a_qsel_in;
   logic [LEVEL_BITS-1:0] a_p_ff, a_p_in;
   logic [LEVEL_BITS-1:0] a_left_ff, a_left_in;
   logic [LEVEL_BITS-1:0] a_above_left_ff, a_above_left_in;
   logic [PIXEL_BITS-1:0] a_bin_row_ff, a_bin_row_in;
   logic [PIXEL_BITS-1:0] a_bin_col_ff, a_bin_col_in;

   // Row buffer: one previous row of gray levels, read data registered.
   logic [LEVEL_BITS-1:0] line_mem [MAX_WIDTH];
   logic [LEVEL_BITS-1:0] rd_above_ff;
   logic [LEVEL_BITS-1:0] rd_next_ff;

   logic [WBITS-1:0]           w_ext, w_eff, col_ext, c1;
   logic [HEIGHT_REG_BITS-1:0] h_eff, r0;
   logic [HEIGHT_REG_BITS:0]   r_pre, r1;
   logic                       wrap_pre, wrap_post;
   logic [COL_BITS-1:0]        c0, above_next_addr, col_next;
   logic [HEIGHT_REG_BITS-1:0] row_next;
   logic [LEVEL_BITS-1:0]      level, above_left_src;
   logic                       pair_valid;
   qsel_type                   qsel;
   logic                       needs_b, a_move, accept, pix_accept;
   logic [LEVEL_BITS-1:0]      q_level;

   // Effective frame size after clamping the registers.
   always_comb begin
      w_ext = WBITS'(cfg.width);
      if (w_ext == '0) begin
         w_eff = WBITS'(1);
      end else if (w_ext > WBITS'(MAX_WIDTH)) begin
         w_eff = WBITS'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      h_eff = (cfg.height == '0) ? HEIGHT_REG_BITS'(1) : cfg.height;
   end

   // Position of this pixel and of the one after it.
   always_comb begin
      col_ext  = WBITS'(col_ff);
      wrap_pre = col_ext >= w_eff;
      c0       = wrap_pre ? '0 : col_ff;
      r_pre    = {1'b0, row_ff} + (HEIGHT_REG_BITS+1)'(wrap_pre);
      r0       = (r_pre >= {1'b0, h_eff}) ? '0 : r_pre[HEIGHT_REG_BITS-1:0];
      c1       = WBITS'(c0) + WBITS'(1);
      wrap_post = c1 >= w_eff;
      above_next_addr = (c1 == WBITS'(MAX_WIDTH)) ? '0 : c1[COL_BITS-1:0];
      col_next = wrap_post ? '0 : c1[COL_BITS-1:0];
      r1       = {1'b0, r0} + (HEIGHT_REG_BITS+1)'(wrap_post);
      row_next = (r1 >= {1'b0, h_eff}) ? '0 : r1[HEIGHT_REG_BITS-1:0];
   end

   // Neighbour choice and whether it lies inside the frame.
   always_comb begin
      case (cfg.direction)
         DIR_LEFT: begin
            pair_valid = c0 != '0;
            qsel       = Q_LEFT;
         end
         DIR_UP_RIGHT: begin
            pair_valid = (r0 != '0) && !wrap_post;
            qsel       = Q_ABOVE_NEXT;
         end
         DIR_UP: begin
            pair_valid = r0 != '0;
            qsel       = Q_ABOVE;
         end
         DIR_UP_LEFT: begin
            pair_valid = (r0 != '0) && (c0 != '0);
            qsel       = Q_ABOVE_LEFT;
         end
         default: begin
            pair_valid = 1'b0;
            qsel       = Q_LEFT;
         end
      endcase
   end

   // Handshake between the input, the held item and the sequencer.
   always_comb begin
      level      = req_pixel[LEVEL_BITS-1:0];
      needs_b    = (a_action_ff == ACTION_READ) || a_pair_ff;
      a_move     = a_valid_ff && (!needs_b || item_ready);
      req_ready  = !hold && (!a_valid_ff || a_move);
      accept     = req_valid && req_ready;
      pix_accept = accept && (req_action == ACTION_PIXEL);
      item_valid = a_valid_ff && needs_b;
      // The previous pixel may still sit here with its above value in the read register.
      above_left_src = (a_valid_ff && (a_action_ff == ACTION_PIXEL)) ? rd_above_ff
                                                                     : above_left_ff;
   end

   // Resolve the neighbour value of the held pixel.
   always_comb begin
      case (a_qsel_ff)
         Q_LEFT:       q_level = a_left_ff;
         Q_ABOVE:      q_level = rd_above_ff;
         Q_ABOVE_NEXT: q_level = rd_next_ff;
         Q_ABOVE_LEFT: q_level = a_above_left_ff;
         default:      q_level = a_left_ff;
      endcase
      item.action  = a_action_ff;
      item.p       = PIXEL_BITS'(a_p_ff);
      item.q       = PIXEL_BITS'(q_level);
      item.bin_row = a_bin_row_ff;
      item.bin_col = a_bin_col_ff;
   end

   // Next state of the position, neighbours and held item.
   always_comb begin
      col_in          = col_ff;
      row_in          = row_ff;
      left_in         = left_ff;
      above_left_in   = above_left_ff;
      a_valid_in      = a_move ? 1'b0 : a_valid_ff;
      a_action_in     = a_action_ff;
      a_pair_in       = a_pair_ff;
      a_qsel_in       = a_qsel_ff;
      a_p_in          = a_p_ff;
      a_left_in       = a_left_ff;
      a_above_left_in = a_above_left_ff;
      a_bin_row_in    = a_bin_row_ff;
      a_bin_col_in    = a_bin_col_ff;
      if (a_move && (a_action_ff == ACTION_PIXEL)) begin
         above_left_in = rd_above_ff;
      end
      if (accept) begin
         a_valid_in      = 1'b1;
         a_action_in     = req_action;
         a_pair_in       = (req_action == ACTION_PIXEL) && pair_valid;
         a_qsel_in       = qsel;
         a_p_in          = level;
         a_left_in       = left_ff;
         a_above_left_in = above_left_src;
         a_bin_row_in    = req_bin_row;
         a_bin_col_in    = req_bin_col;
      end
      if (pix_accept) begin
         col_in  = col_next;
         row_in  = row_next;
         left_in = level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         left_ff       <= '0;
         above_left_ff <= '0;
         a_valid_ff    <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_ff       <= left_in;
         above_left_ff <= above_left_in;
         a_valid_ff    <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_action_ff     <= a_action_in;
      a_pair_ff       <= a_pair_in;
      a_qsel_ff       <= a_qsel_in;
      a_p_ff          <= a_p_in;
      a_left_ff       <= a_left_in;
      a_above_left_ff <= a_above_left_in;
      a_bin_row_ff    <= a_bin_row_in;
      a_bin_col_ff    <= a_bin_col_in;
   end

   // Row buffer: read the old values, then store the new pixel in its column.
   always_ff @(posedge clock) begin
      if (pix_accept) begin
         rd_above_ff  <= line_mem[c0];
         rd_next_ff   <= line_mem[above_next_addr];
         line_mem[c0] <= level;
      end
   end

endmodule

/* design/gpc_pair_seq.sv */
module gpc_pair_seq #(
   parameter int LEVEL_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  gpc_pkg::pair_item_type        item,
   output logic                          item_ready,
   input  logic                          rd_ok,
   output gpc_pkg::bin_slot_type         slot,
   output logic [2*LEVEL_BITS-1:0]       slot_addr
);
   import gpc_pkg::*;

   localparam int ADDR_BITS = 2 * LEVEL_BITS;

   logic                 b_valid_ff, b_valid_in;
   logic                 b_read_ff, b_read_in;
   logic                 b_twice_ff, b_twice_in;
   logic                 b_second_ff, b_second_in;
   logic [ADDR_BITS-1:0] b_addr1_ff, b_addr1_in;
   logic [ADDR_BITS-1:0] b_addr2_ff, b_addr2_in;

   logic                  done, load;
   logic [LEVEL_BITS-1:0] p_lvl, q_lvl;

   // Issue one bin operation per cycle for the held item; a read waits for rd_ok.
   always_comb begin
      slot.valid = 1'b0;
      slot.op    = OP_INC1;
      slot_addr  = b_addr1_ff;
      done       = 1'b0;
      if (b_valid_ff) begin
         if (b_read_ff) begin
            slot.valid = rd_ok;
            slot.op    = OP_CLEAR;
            done       = rd_ok;
         end else if (!b_twice_ff) begin
            slot.valid = 1'b1;
            slot.op    = OP_INC2;
            done       = 1'b1;
         end else if (!b_second_ff) begin
            slot.valid = 1'b1;
         end else begin
            slot.valid = 1'b1;
            slot_addr  = b_addr2_ff;
            done       = 1'b1;
         end
      end
      item_ready = !b_valid_ff || done;
      load       = item_valid && item_ready;
   end

   // Load a new item: a read names one bin, a pixel pair names one or two.
   always_comb begin
      p_lvl       = item.p[LEVEL_BITS-1:0];
      q_lvl       = item.q[LEVEL_BITS-1:0];
      b_valid_in  = b_valid_ff && !done;
      b_read_in   = b_read_ff;
      b_twice_in  = b_twice_ff;
      b_second_in = b_second_ff;
      b_addr1_in  = b_addr1_ff;
      b_addr2_in  = b_addr2_ff;
      if (b_valid_ff && !b_read_ff && b_twice_ff && !b_second_ff) begin
         b_second_in = 1'b1;
      end
      if (load) begin
         b_valid_in  = 1'b1;
         b_read_in   = item.action == ACTION_READ;
         b_twice_in  = (item.action == ACTION_PIXEL) && (p_lvl != q_lvl);
         b_second_in = 1'b0;
         if (item.action == ACTION_READ) begin
            b_addr1_in = {item.bin_row[LEVEL_BITS-1:0], item.bin_col[LEVEL_BITS-1:0]};
         end else begin
            b_addr1_in = {p_lvl, q_lvl};
         end
         b_addr2_in = {q_lvl, p_lvl};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         b_second_ff <= 1'b0;
      end else begin
         b_valid_ff  <= b_valid_in;
         b_second_ff <= b_second_in;
      end
   end

   always_ff @(posedge clock) begin
      b_read_ff  <= b_read_in;
      b_twice_ff <= b_twice_in;
      b_addr1_ff <= b_addr1_in;
      b_addr2_ff <= b_addr2_in;
   end

endmodule

/* design/gpc_bin_store.sv */
module gpc_bin_store #(
   parameter int LEVEL_BITS = 8,
   parameter int COUNT_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gpc_pkg::bin_slot_type                slot,
   input  logic [2*LEVEL_BITS-1:0]              slot_addr,
   output logic                                 rd_ok,
   output logic                                 clearing,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gpc_pkg::COUNT_OUT_BITS-1:0]   rsp_count
);
   import gpc_pkg::*;

   localparam int ADDR_BITS = 2 * LEVEL_BITS;
   localparam int DEPTH     = 1 << ADDR_BITS;

   // Bin memory, one write and one registered read per cycle.
   logic [COUNT_BITS-1:0] bin_mem [DEPTH];
   logic [COUNT_BITS-1:0] rdata_ff;

   logic                  clr_busy_ff, clr_busy_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic                  d_valid_ff, d_valid_in;
   bin_op_type            d_op_ff, d_op_in;
   logic [ADDR_BITS-1:0]  d_addr_ff, d_addr_in;
   logic                  wr_valid_ff, wr_valid_in;
   logic [ADDR_BITS-1:0]  wr_addr_ff, wr_addr_in;
   logic [COUNT_BITS-1:0] wr_data_ff, wr_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [COUNT_BITS-1:0]     cur, new_count;
   logic [COUNT_BITS:0]       sum;
   logic [COUNT_OUT_BITS-1:0] sat_out;
   logic                      d_read;

   // Current count: forward the write of the slot just before when it hit the same bin.
   always_comb begin
      cur = (wr_valid_ff && (wr_addr_ff == d_addr_ff)) ? wr_data_ff : rdata_ff;
      sum = {1'b0, cur} + ((d_op_ff == OP_INC2) ? (COUNT_BITS+1)'(2) : (COUNT_BITS+1)'(1));
      case (d_op_ff)
         OP_INC1, OP_INC2: new_count = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
         OP_CLEAR:         new_count = '0;
         default:          new_count = cur;
      endcase
   end

   // Saturate the count to the width of the result stream.
   generate
      if (COUNT_BITS > COUNT_OUT_BITS) begin : g_sat
         assign sat_out = (|cur[COUNT_BITS-1:COUNT_OUT_BITS]) ? '1 : cur[COUNT_OUT_BITS-1:0];
      end else begin : g_ext
         assign sat_out = COUNT_OUT_BITS'(cur);
      end
   endgenerate

   // A read may issue only when its result is sure to find the output register free.
   always_comb begin
      d_read    = d_valid_ff && (d_op_ff == OP_CLEAR);
      rd_ok     = !d_read && (!rsp_valid_ff || rsp_ready);
      clearing  = clr_busy_ff;
      rsp_valid = rsp_valid_ff;
      rsp_count = rsp_data_ff;
   end

   always_comb begin
      clr_busy_in  = clr_busy_ff && (clr_addr_ff != '1);
      clr_addr_in  = clr_busy_ff ? clr_addr_ff + ADDR_BITS'(1) : clr_addr_ff;
      d_valid_in   = slot.valid;
      d_op_in      = slot.op;
      d_addr_in    = slot_addr;
      wr_valid_in  = d_valid_ff;
      wr_addr_in   = d_addr_ff;
      wr_data_in   = new_count;
      rsp_valid_in = d_read ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = d_read ? sat_out : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         d_valid_ff   <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         d_valid_ff   <= d_valid_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_op_ff     <= d_op_in;
      d_addr_ff   <= d_addr_in;
      wr_addr_ff  <= wr_addr_in;
      wr_data_ff  <= wr_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Memory port: the clearing pass or the write-back, and the slot read.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         bin_mem[clr_addr_ff] <= '0;
      end else if (d_valid_ff) begin
         bin_mem[d_addr_ff] <= new_count;
      end
      if (slot.valid) begin
         rdata_ff <= bin_mem[slot_addr];
      end
   end

endmodule

/* design/glcm_pair_counter_unit.sv */
// Channel  Direction  Fields (lowest bit first)
// req_     in         tdata: pixel, bin_row, bin_col; tuser: action
// rsp_     out        tdata: pair_count
// csr_     in         csr_index selects image_width, image_height, direction
//
// A pixel updates both bins of its pair when the levels differ, one bin by two when
// they are equal and none without a neighbour in the frame. Reads never issue back to
// back; a read passes the held item, the sequencer and the bin read stage to the
// result register of rsp_tvalid. After reset a clearing pass over all 2^(2*LEVEL_BITS)
// bins (65536 by default) holds req_tready low; register writes are taken throughout.
// A stalled result holds back the next read and every transaction behind it.
module glcm_pair_counter_unit #(
   parameter int MAX_WIDTH  = 4096,
   parameter int LEVEL_BITS = 8,
   parameter int COUNT_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [gpc_pkg::REQ_DATA_BITS-1:0]     req_tdata,  // pixel, bin_row, bin_col
   input  logic                                  req_tuser,  // action
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gpc_pkg::COUNT_OUT_BITS-1:0]    rsp_tdata,  // pair_count
   input  logic                                  csr_we,
   input  logic [gpc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [gpc_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import gpc_pkg::*;

   cfg_type                   cfg_ff, cfg_in;
   action_type                req_action;
   logic [PIXEL_BITS-1:0]     req_pixel, req_bin_row, req_bin_col;
   logic                      clearing, item_valid, item_ready, rd_ok;
   pair_item_type             item;
   bin_slot_type              slot;
   logic [2*LEVEL_BITS-1:0]   slot_addr;

   // Unpack the request transaction.
   always_comb begin
      req_action  = action_type'(req_tuser);
      req_pixel   = req_tdata[PIXEL_BITS-1:0];
      req_bin_row = req_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
      req_bin_col = req_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS];
   end

   // Configuration registers; writes beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_IMAGE_WIDTH:  cfg_in.width     = csr_data[WIDTH_REG_BITS-1:0];
            REG_IMAGE_HEIGHT: cfg_in.height    = csr_data[HEIGHT_REG_BITS-1:0];
            REG_DIRECTION:    cfg_in.direction = direction_type'(csr_data[DIR_REG_BITS-1:0]);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width     <= WIDTH_RESET;
         cfg_ff.height    <= HEIGHT_RESET;
         cfg_ff.direction <= DIR_LEFT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gpc_pixel_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_action  (req_action),
      .req_pixel   (req_pixel),
      .req_bin_row (req_bin_row),
      .req_bin_col (req_bin_col),
      .cfg         (cfg_ff),
      .hold        (clearing),
      .item_valid  (item_valid),
      .item        (item),
      .item_ready  (item_ready)
   );

   gpc_pair_seq #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .rd_ok      (rd_ok),
      .slot       (slot),
      .slot_addr  (slot_addr)
   );

   gpc_bin_store #(
      .LEVEL_BITS (LEVEL_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_bins (
      .clock     (clock),
      .reset     (reset),
      .slot      (slot),
      .slot_addr (slot_addr),
      .rd_ok     (rd_ok),
      .clearing  (clearing),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_count (rsp_tdata)
   );

endmodule

/* design/gpc_port_check.sv */
`include "glcm_pair_counter_unit_assert.svh"

module gpc_port_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Reset starts the clearing pass, so no request transaction is taken next cycle.
   `GPC_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_tready)

   // No result survives a reset.
   `GPC_ASSERT_NEXT(a_rsp_idle_after_reset, clock, 1'b0, reset, !rsp_tvalid)

   // A stalled result holds its value.
   `GPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))

   // Reads never issue back to back, so result transactions never come back to back either.
   `GPC_ASSERT_NEXT(a_rsp_spacing, clock, reset, rsp_tvalid && rsp_tready,
                    !(rsp_tvalid && rsp_tready))

endmodule

bind glcm_pair_counter_unit gpc_port_check u_port_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/tb_glcm_pair_counter_unit.sv */
`timescale 1ns / 100ps

import gpc_pkg::*;

// Predicts the co-occurrence bins and keeps the pair counts that reads must return.
class glcm_count_board;
   bit [31:0]     bin_count [65536];
   bit [7:0]      row_above [4096];
   bit [7:0]      left_level;
   bit [7:0]      upleft_level;
   int unsigned   col_pos;
   int unsigned   row_pos;
   bit [12:0]     width_reg;
   bit [15:0]     height_reg;
   direction_type dir_reg;
   bit [31:0]     expected_counts [$];
   int            errors;

   function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      dir_reg    = DIR_LEFT;
   endfunction

   function void write_reg(csr_reg_type idx, int unsigned value);
      case (idx)
         REG_IMAGE_WIDTH:  width_reg = value[12:0];
         REG_IMAGE_HEIGHT: height_reg = value[15:0];
         REG_DIRECTION:    dir_reg = direction_type'(value[1:0]);
         default: ;
      endcase
   endfunction

   // True when the next pixel opens a fresh frame.
   function bit at_frame_start();
      return (row_pos == 0) && (col_pos == 0);
   endfunction

   // Counts saturate at the all-ones value.
   function void bump_bin(bit [7:0] a, bit [7:0] b);
      if (bin_count[{a, b}] != 32'hFFFF_FFFF) bin_count[{a, b}]++;
   endfunction

   // Applies one accepted transaction to the predicted state.
   function void take_request(action_type act, bit [7:0] level, bit [7:0] brow,
                              bit [7:0] bcol);
      int unsigned w;
      int unsigned h;
      bit [7:0]    q;
      bit [7:0]    above;
      bit          paired;
      if (act == ACTION_READ) begin
         expected_counts.push_back(bin_count[{brow, bcol}]);
         bin_count[{brow, bcol}] = '0;
         return;
      end
      w = width_reg;
      if (w < 1) w = 1;
      if (w > 4096) w = 4096;
      h = (height_reg != 0) ? height_reg : 1;
      // A position left beyond the frame by a register change moves on first.
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      case (dir_reg)
         DIR_LEFT: begin
            paired = (col_pos > 0);
            q = left_level;
         end
         DIR_UP_RIGHT: begin
            paired = (row_pos > 0) && (col_pos + 1 < w);
            q = row_above[(col_pos + 1) % 4096];
         end
         DIR_UP: begin
            paired = (row_pos > 0);
            q = row_above[col_pos % 4096];
         end
         default: begin
            paired = (row_pos > 0) && (col_pos > 0);
            q = upleft_level;
         end
      endcase
      if (paired) begin
         bump_bin(level, q);
         bump_bin(q, level);
      end
      above = row_above[col_pos % 4096];
      row_above[col_pos % 4096] = level;
      upleft_level = above;
      left_level = level;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   // Compares one accepted result with the oldest predicted count.
   function void check_count(logic [31:0] got);
      bit [31:0] want;
      if (expected_counts.size() == 0) begin
         $display("%0t: pair_count %0h arrived with no read outstanding", $time, got);
         errors++;
         return;
      end
      want = expected_counts.pop_front();
      if (got !== want) begin
         $display("%0t: pair_count mismatch, expected %0h, actual %0h", $time, want, got);
         errors++;
      end
   endfunction
endclass

module tb_glcm_pair_counter_unit;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // pixel, bin_row, bin_col
   logic        req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // pair_count
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   glcm_count_board board = new();

   int          sender_idle_pct;
   int          sink_stall_pct;
   int          hold_request;
   int          hold_left;

   glcm_pair_counter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Hard stop well beyond the slowest correct run, including the clearing pass.
   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end

   // Result side: random stalls, plus a long counted hold-off when requested.
   initial begin
      rsp_tready <= 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Every result transaction is checked against the prediction.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) board.check_count(rsp_tdata);
      end
   end

   // Offers one transaction, idling first at random; returns at the next falling edge.
   task automatic send_item(action_type act, bit [7:0] level, bit [7:0] brow,
                            bit [7:0] bcol);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {bcol, brow, level};
      do @(posedge clock); while (!req_tready);
      board.take_request(act, level, brow, bcol);
      @(negedge clock);
   endtask

   task automatic send_pixel(bit [7:0] level);
      send_item(ACTION_PIXEL, level, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   task automatic send_read(bit [7:0] brow, bit [7:0] bcol);
      send_item(ACTION_READ, 8'($urandom_range(255)), brow, bcol);
   endtask

   task automatic csr_write(csr_reg_type idx, int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[15:0];
      @(posedge clock);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every read has answered and the pixel pipeline has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.expected_counts.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   // The width only changes at the start of a frame, so that the row buffer is
   // never read where the current frame has not written it. To get there the
   // height is dropped to one and the rest of the row is filled with pixels.
   task automatic set_geometry(int unsigned w, int unsigned h, direction_type d);
      drain();
      if (board.width_reg != w[12:0]) begin
         if (!board.at_frame_start()) begin
            if (board.height_reg != 16'd1) csr_write(REG_IMAGE_HEIGHT, 1);
            while (!board.at_frame_start()) send_pixel(8'($urandom_range(255)));
            drain();
         end
         csr_write(REG_IMAGE_WIDTH, w);
      end
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_DIRECTION, d);
   endtask

   // Mostly levels from a small palette, so that bins fill up and reads hit them.
   function automatic bit [7:0] pick_level(bit [7:0] pal [4]);
      if ($urandom_range(99) < 85) return pal[$urandom_range(3)];
      return 8'($urandom_range(255));
   endfunction

   task automatic run_phase(int count, int read_pct, bit [7:0] pal [4]);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < read_pct) send_read(pick_level(pal), pick_level(pal));
         else send_pixel(pick_level(pal));
      end
   endtask

   initial begin
      bit [7:0]      pal [4];
      int unsigned   w;
      int unsigned   h;
      direction_type d;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= ACTION_PIXEL;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= REG_IMAGE_WIDTH;
      csr_data   <= '0;
      sender_idle_pct = 0;
      sink_stall_pct  = 0;
      hold_request    = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extreme levels, equal pairs, reads that clear, every direction.
      set_geometry(3, 3, DIR_LEFT);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_read(8'd0, 8'd255);
      send_read(8'd255, 8'd0);
      send_read(8'd255, 8'd255);
      send_read(8'd255, 8'd255);
      set_geometry(3, 3, DIR_UP);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd128);
      send_read(8'd255, 8'd0);
      set_geometry(3, 3, DIR_UP_RIGHT);
      send_pixel(8'd1);
      send_pixel(8'd2);
      send_pixel(8'd3);
      send_read(8'd2, 8'd128);
      set_geometry(3, 3, DIR_UP_LEFT);
      repeat (6) send_pixel(8'd9);
      send_read(8'd9, 8'd9);
      send_read(8'd0, 8'd0);

      // Random phases over several geometries and idling patterns.
      for (int ph = 0; ph < 12; ph++) begin
         w = $urandom_range(12, 2);
         h = $urandom_range(6, 1);
         d = direction_type'((ph + ph / 4) % 4);
         if (ph == 3) begin
            w = 1;
            h = 65535;
            d = DIR_UP;
         end
         if (ph == 7) h = 1;
         if (ph == 11) begin
            w = 4096;
            h = 2;
         end
         set_geometry(w, h, d);
         case (ph % 4)
            0: begin
               sender_idle_pct = 0;
               sink_stall_pct  = 0;
            end
            1: begin
               sender_idle_pct = 87;
               sink_stall_pct  = 0;
            end
            2: begin
               sender_idle_pct = 0;
               sink_stall_pct  = 87;
            end
            default: begin
               sender_idle_pct = 30;
               sink_stall_pct  = 30;
            end
         endcase
         foreach (pal[i]) pal[i] = 8'($urandom_range(255));
         // A long hold-off on results while reads keep coming fills the block.
         if (ph == 4) hold_request = 400;
         run_phase(145, (ph == 4) ? 90 : 30, pal);
      end

      req_tvalid <= 1'b0;
      while (board.expected_counts.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+design
design/gpc_pkg.sv
design/gpc_pixel_front.sv
design/gpc_pair_seq.sv
design/gpc_bin_store.sv
design/glcm_pair_counter_unit.sv
design/gpc_port_check.sv
bench/tb_glcm_pair_counter_unit.sv
